[rtl/core/topic_filter_wildcard_matcher_top_assert.svh]
// ----------------------------------------------------------------------------
// topic filter matcher assertion macros
// concurrent checks clocked on clk_i, quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef TOPIC_FILTER_WILDCARD_MATCHER_TOP_ASSERT_SVH
`define TOPIC_FILTER_WILDCARD_MATCHER_TOP_ASSERT_SVH

// check a property on every rising clock edge outside reset
`define TFWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that one condition implies another in the same cycle
`define TFWM_ASSERT_IMPL(lbl, ante, cons, msg) \
  `TFWM_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/core/tfwm_pkg.sv]
// ----------------------------------------------------------------------------
// tfwm_pkg
// sizes, character codes and operation codes of the topic filter matcher
// ----------------------------------------------------------------------------
package tfwm_pkg;

  // filter store depth in bytes
  localparam int FILTER_DEPTH = 64;

  // cursor holds 0 .. FILTER_DEPTH
  localparam int CURW = $clog2(FILTER_DEPTH + 1);
  // working width for cursor arithmetic and byte addresses
  localparam int AW = (CURW + 2 > 8) ? CURW + 2 : 8;

  // filter store split into four banks, address bits [1:0] pick the bank
  localparam int NUM_BANKS = 4;
  localparam int ROWS = (FILTER_DEPTH + NUM_BANKS - 1) / NUM_BANKS;
  localparam int ROWW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // window of filter bytes at cursor-1 .. cursor+2
  localparam int WIN = 4;

  localparam int LENW = 7;
  localparam int SLOTW = 6;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef enum logic {
    OP_FILTER_WRITE = 1'b0,
    OP_NAME_BYTE    = 1'b1
  } op_e;

endpackage

[rtl/core/topic_filter_wildcard_matcher_top.sv]
// ----------------------------------------------------------------------------
// topic_filter_wildcard_matcher_top: mqtt topic filter wildcard matcher
// throughput one item per cycle while not stalled: one walk step per name byte on a
//   prefetched four-byte filter window, refetched from four filter banks every cycle
// result path: the last name byte passes the input register, then the result register
//   drives match_o and out_valid_o; input stalls only while a result waits on out_stall_i
// async active-low reset clears walk state, length to 1; no clearing pass
// ----------------------------------------------------------------------------
module topic_filter_wildcard_matcher_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration: filter length
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tfwm_pkg::LENW-1:0]  cfg_data_i,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [tfwm_pkg::SLOTW-1:0] filter_slot_i,
  input  logic [7:0]                 char_byte_i,
  input  logic                       last_byte_i,
  // results
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       match_o
);
  import tfwm_pkg::*;

  `include "topic_filter_wildcard_matcher_top_assert.svh"

  // ---------------------------------------------------------------------------
  // configuration register, always ready
  // ---------------------------------------------------------------------------
  logic [LENW-1:0] len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LENW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      len_q <= cfg_data_i;
    end
  end

  // effective length: zero acts as one, clamp to the store depth
  logic [AW-1:0] len_x;

  always_comb begin
    if (len_q == '0) begin
      len_x = AW'(1);
    end else if (AW'(len_q) > AW'(FILTER_DEPTH)) begin
      len_x = AW'(FILTER_DEPTH);
    end else begin
      len_x = AW'(len_q);
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic             in_valid_q;
  op_e              in_op_q;
  logic [SLOTW-1:0] in_slot_q;
  logic [7:0]       in_char_q;
  logic             in_last_q;

  logic in_accept;
  logic produces;
  logic adv;

  // a last name byte needs the result register to be free or emptying
  assign produces   = (in_op_q == OP_NAME_BYTE) && in_last_q;
  assign adv        = in_valid_q && (!produces || !out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q   <= op_e'(operation_i);
      in_slot_q <= filter_slot_i;
      in_char_q <= char_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // walk state
  // ---------------------------------------------------------------------------
  logic [CURW-1:0] cursor_q;
  logic            skip_q;
  logic            dec_q;
  logic            dv_q;

  // filter window bytes at cursor-1, cursor, cursor+1, cursor+2
  logic [7:0] win_byte [WIN];
  logic [7:0] fm1, f0, f1, f2;

  assign fm1 = win_byte[0];
  assign f0  = win_byte[1];
  assign f1  = win_byte[2];
  assign f2  = win_byte[3];

  logic [AW-1:0] fi_x;
  logic          lvl_start;
  logic          end_sp;

  assign fi_x      = AW'(cursor_q);
  // a wildcard is only legal at the start of a filter level
  assign lvl_start = (fi_x == '0) || (fm1 == CH_SLASH);

  // end-of-name acceptance for filters ending in "/#" or "/+"
  always_comb begin
    end_sp = (len_x >= AW'(3)) && (fi_x + AW'(3) == len_x) &&
             (f1 == CH_SLASH) && (f2 == CH_HASH);
    if ((fi_x + AW'(2) == len_x) && (f0 == CH_SLASH)) begin
      end_sp = (f1 == CH_PLUS) || (f1 == CH_HASH);
    end
  end

  // one step of the lockstep walk
  logic [AW-1:0] fi_n;
  logic          skip_n;
  logic          dec_n;
  logic          dv_n;

  always_comb begin
    fi_n   = fi_x;
    skip_n = skip_q;
    dec_n  = dec_q;
    dv_n   = dv_q;
    if (!dec_q) begin
      if (!skip_q) begin
        priority if (fi_x >= len_x) begin
          // name runs past the filter
          dec_n = 1'b1;
          dv_n  = 1'b0;
        end else if (in_char_q == f0) begin
          if (in_last_q) begin
            dec_n = 1'b1;
            dv_n  = end_sp || (fi_x + AW'(1) == len_x);
          end else begin
            fi_n = fi_x + AW'(1);
          end
        end else begin
          priority if ((f0 == CH_PLUS) && lvl_start) begin
            skip_n = 1'b1;
          end else if ((f0 == CH_HASH) && (fi_x + AW'(1) == len_x) && lvl_start) begin
            dec_n = 1'b1;
            dv_n  = 1'b1;
          end else begin
            dec_n = 1'b1;
            dv_n  = 1'b0;
          end
        end
      end
      // level skip, includes the byte that reached the '+'
      if (skip_n && !dec_n) begin
        priority if (in_char_q == CH_SLASH) begin
          if ((fi_x + AW'(1) < len_x) && (f1 == CH_SLASH)) begin
            fi_n   = fi_x + AW'(2);
            skip_n = 1'b0;
            if (in_last_q) begin
              dec_n = 1'b1;
              dv_n  = (fi_x + AW'(2) == len_x);
            end
          end else begin
            dec_n = 1'b1;
            dv_n  = 1'b0;
          end
        end else if (in_last_q) begin
          dec_n = 1'b1;
          dv_n  = (fi_x + AW'(1) == len_x);
        end else begin
          // keep skipping
          dec_n = dec_n;
        end
      end
    end
  end

  logic name_step;
  logic [CURW-1:0] cursor_d;

  assign name_step = adv && (in_op_q == OP_NAME_BYTE);

  always_comb begin
    cursor_d = cursor_q;
    if (name_step) begin
      cursor_d = in_last_q ? '0 : fi_n[CURW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      skip_q   <= 1'b0;
      dec_q    <= 1'b0;
      dv_q     <= 1'b0;
    end else if (name_step) begin
      // end of name returns the walk to its start
      cursor_q <= cursor_d;
      skip_q   <= in_last_q ? 1'b0 : skip_n;
      dec_q    <= in_last_q ? 1'b0 : dec_n;
      dv_q     <= in_last_q ? 1'b0 : dv_n;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && produces) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && produces) begin
      match_q <= dec_n && dv_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign match_o     = match_q;

  // ---------------------------------------------------------------------------
  // filter store: four banks, each read once per cycle for the next window
  // ---------------------------------------------------------------------------
  logic [7:0] filter_mem_q [NUM_BANKS][ROWS];

  logic          wr_en;
  logic [AW-1:0] wr_addr;

  assign wr_addr = AW'(in_slot_q);
  // writes beyond the store are dropped
  assign wr_en   = adv && (in_op_q == OP_FILTER_WRITE) && (wr_addr < AW'(FILTER_DEPTH));

  // window addresses for the cursor that the next item sees
  logic [AW-1:0]   rd_addr [WIN];
  logic [WIN-1:0]  rd_ok;
  logic [ROWW-1:0] rd_row  [NUM_BANKS];
  logic [NUM_BANKS-1:0] rd_hit;

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      rd_addr[k] = AW'(cursor_d) + AW'(k) - AW'(1);
      rd_ok[k]   = ((AW'(cursor_d) + AW'(k)) != '0) && (rd_addr[k] < AW'(FILTER_DEPTH));
    end
    for (int b = 0; b < NUM_BANKS; b++) begin
      rd_row[b] = '0;
      for (int k = 0; k < WIN; k++) begin
        if (rd_addr[k][1:0] == 2'(b)) begin
          rd_row[b] = rd_addr[k][ROWW+1:2];
        end
      end
      // forward a write that lands on the byte being fetched
      rd_hit[b] = wr_en && (wr_addr[1:0] == 2'(b)) && (wr_addr[ROWW+1:2] == rd_row[b]);
    end
  end

  logic [7:0]           bank_rd_q [NUM_BANKS];
  logic [NUM_BANKS-1:0] hit_q;
  logic [7:0]           fwd_q;
  logic [WIN-1:0]       win_ok_q;
  logic [1:0]           base_q;

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (wr_en && (wr_addr[1:0] == 2'(b))) begin
        filter_mem_q[b][wr_addr[ROWW+1:2]] <= in_char_q;
      end
      bank_rd_q[b] <= filter_mem_q[b][rd_row[b]];
    end
    hit_q    <= rd_hit;
    fwd_q    <= in_char_q;
    win_ok_q <= rd_ok;
    base_q   <= rd_addr[0][1:0];
  end

  // rotate bank outputs into window order, bytes outside the store read zero
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      logic [1:0] bi;
      bi = base_q + 2'(k);
      if (!win_ok_q[k]) begin
        win_byte[k] = '0;
      end else if (hit_q[bi]) begin
        win_byte[k] = fwd_q;
      end else begin
        win_byte[k] = bank_rd_q[bi];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `TFWM_ASSERT_IMPL(a_dv_needs_dec, dv_q, dec_q, "decided value set without a decision")
  `TFWM_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
                    "input stalled while result register can take a result")
  `TFWM_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(adv && produces),
               "result appeared without a last name byte")
  `TFWM_ASSERT(a_walk_cleared, (name_step && in_last_q) |=>
               (cursor_q == '0) && !skip_q && !dec_q,
               "walk state not cleared after end of name")

endmodule
